// ----- rtl/core/fpa_pkg.sv -----
`timescale 1ns / 1ps
package fpa_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned WIDE_W    = 64;
  localparam int unsigned OP_W      = 3;
  localparam int unsigned SHIFT_W   = 5;
  localparam int unsigned FRAC_BITS = 8;

  // Multiply retires one multiplier bit per cycle; divide one quotient bit per
  // cycle over the whole scaled dividend.
  localparam int unsigned MUL_ITER = DATA_W;
  localparam int unsigned DIV_ITER = DATA_W + FRAC_BITS;
  localparam int unsigned CNT_W    = $clog2(DIV_ITER);

  localparam logic [OP_W-1:0] OP_SHL = 3'd0;
  localparam logic [OP_W-1:0] OP_SAR = 3'd1;
  localparam logic [OP_W-1:0] OP_ADD = 3'd2;
  localparam logic [OP_W-1:0] OP_SUB = 3'd3;
  localparam logic [OP_W-1:0] OP_MUL = 3'd4;
  localparam logic [OP_W-1:0] OP_DIV = 3'd5;
  localparam logic [OP_W-1:0] OP_INC = 3'd6;
  localparam logic [OP_W-1:0] OP_DEC = 3'd7;

  // Decoded sequencer state handed to the datapath.
  typedef struct packed {
    logic idle;
    logic simple;
    logic absa;
    logic absb;
    logic mul;
    logic div;
    logic neg;
    logic fin;
    logic is_mul;
  } ctl_t;

endpackage

// ----- rtl/core/fpa_addsub.sv -----
`timescale 1ns / 1ps
module fpa_addsub (
  input  logic [fpa_pkg::WIDE_W-1:0] x,
  input  logic [fpa_pkg::WIDE_W-1:0] y,
  input  logic                       sub,
  output logic [fpa_pkg::WIDE_W-1:0] sum
);

  logic [fpa_pkg::WIDE_W-1:0] y_eff;

  assign y_eff = sub ? ~y : y;
  assign sum   = x + y_eff + {{(fpa_pkg::WIDE_W-1){1'b0}}, sub};

endmodule

// ----- rtl/core/fpa_seq.sv -----
`timescale 1ns / 1ps
module fpa_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [fpa_pkg::OP_W-1:0] op,
  input  logic                     div_zero,
  input  logic                     out_free,
  output fpa_pkg::ctl_t            ctl
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SIMPLE = 3'd1;
  localparam logic [2:0] S_ABSA   = 3'd2;
  localparam logic [2:0] S_ABSB   = 3'd3;
  localparam logic [2:0] S_MUL    = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_NEG    = 3'd6;
  localparam logic [2:0] S_FIN    = 3'd7;

  localparam logic [fpa_pkg::CNT_W-1:0] MUL_LAST = fpa_pkg::CNT_W'(fpa_pkg::MUL_ITER - 1);
  localparam logic [fpa_pkg::CNT_W-1:0] DIV_LAST = fpa_pkg::CNT_W'(fpa_pkg::DIV_ITER - 1);

  logic [2:0]                  state_r, state_nxt;
  logic [fpa_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                        is_mul_r, is_mul_nxt;
  logic                        last;

  assign last = is_mul_r ? (cnt_r == MUL_LAST) : (cnt_r == DIV_LAST);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    is_mul_nxt = is_mul_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          is_mul_nxt = (op == fpa_pkg::OP_MUL);
          if (op inside {fpa_pkg::OP_MUL, fpa_pkg::OP_DIV}) begin
            state_nxt = div_zero ? S_FIN : S_ABSA;
          end else begin
            state_nxt = S_SIMPLE;
          end
        end
      end
      S_SIMPLE: state_nxt = S_FIN;
      S_ABSA:   state_nxt = S_ABSB;
      S_ABSB: begin
        cnt_nxt   = '0;
        state_nxt = is_mul_r ? S_MUL : S_DIV;
      end
      S_MUL, S_DIV: begin
        cnt_nxt = cnt_r + 1'b1;
        if (last) begin
          state_nxt = S_NEG;
        end
      end
      S_NEG: state_nxt = S_FIN;
      S_FIN: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      is_mul_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      is_mul_r <= is_mul_nxt;
    end
  end

  always_comb begin
    ctl        = '0;
    ctl.idle   = (state_r == S_IDLE);
    ctl.simple = (state_r == S_SIMPLE);
    ctl.absa   = (state_r == S_ABSA);
    ctl.absb   = (state_r == S_ABSB);
    ctl.mul    = (state_r == S_MUL);
    ctl.div    = (state_r == S_DIV);
    ctl.neg    = (state_r == S_NEG);
    ctl.fin    = (state_r == S_FIN);
    ctl.is_mul = is_mul_r;
  end

endmodule

// ----- rtl/core/fixed_point_accumulator_alu_core.sv -----
`timescale 1ns / 1ps
// Signed 32-bit fixed-point accumulator (FRAC_BITS fraction bits) driven by one operation per
// input beat; each beat returns one output beat with the new accumulator and a divide-by-zero
// flag. All arithmetic but the shifts runs through a single 64-bit adder/subtractor under a
// small sequencer. Shifts, add, subtract, increment and decrement pass through the simple
// step and then the finish state; multiply takes two magnitude steps, 32 shift-add steps and
// a sign fix-up; divide takes the magnitude steps, the restoring divider retiring one quotient
// bit per cycle, and a sign fix-up. A divide by zero goes straight to the finish state.
// The input is ready only while the sequencer is idle, but a finished result may wait
// in the output register while the next beat is accepted.
module fixed_point_accumulator_alu_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [fpa_pkg::OP_W-1:0]           in_op,
  input  logic signed [fpa_pkg::DATA_W-1:0]  in_operand,
  input  logic [fpa_pkg::SHIFT_W-1:0]        in_shift_amount,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [fpa_pkg::DATA_W-1:0]  out_value,
  output logic                               out_div_by_zero
);

  localparam int unsigned DW = fpa_pkg::DATA_W;
  localparam int unsigned WW = fpa_pkg::WIDE_W;
  localparam int unsigned VW = fpa_pkg::DIV_ITER;

  fpa_pkg::ctl_t ctl;

  logic                         in_acc;
  logic                         out_free;
  logic                         div_zero;

  logic [DW-1:0]                acc_r;
  logic [fpa_pkg::OP_W-1:0]     op_r;
  logic [DW-1:0]                b_r;
  logic [fpa_pkg::SHIFT_W-1:0]  sh_r;
  logic                         flag_r;
  logic                         neg_r;
  logic [DW-1:0]                ma_r;
  logic [DW-1:0]                mb_r;
  logic [DW-1:0]                hi_r;
  logic [DW-1:0]                lo_r;
  logic [VW-1:0]                dvd_r;
  logic [DW-1:0]                res_r;

  logic                         out_valid_r;
  logic [DW-1:0]                out_value_r;
  logic                         out_flag_r;

  logic [WW-1:0]                u_x, u_y, u_sum;
  logic                         u_sub;
  logic [WW-1:0]                prod;
  logic [DW-1:0]                simple_res;
  logic                         q_bit;

  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign div_zero = (in_op == fpa_pkg::OP_DIV) && (in_operand == '0);
  assign in_ready = ctl.idle;

  fpa_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_acc),
    .op       (in_op),
    .div_zero (div_zero),
    .out_free (out_free),
    .ctl      (ctl)
  );

  fpa_addsub u_addsub (
    .x   (u_x),
    .y   (u_y),
    .sub (u_sub),
    .sum (u_sum)
  );

  // Operand selection for the shared adder, one use per sequencer state.
  always_comb begin
    u_x   = '0;
    u_y   = '0;
    u_sub = 1'b0;
    if (ctl.simple) begin
      u_x   = {{(WW-DW){acc_r[DW-1]}}, acc_r};
      u_y   = (op_r == fpa_pkg::OP_INC || op_r == fpa_pkg::OP_DEC)
              ? WW'(1) : {{(WW-DW){b_r[DW-1]}}, b_r};
      u_sub = (op_r == fpa_pkg::OP_SUB) || (op_r == fpa_pkg::OP_DEC);
    end else if (ctl.absa) begin
      u_y   = {{(WW-DW){acc_r[DW-1]}}, acc_r};
      u_sub = acc_r[DW-1];
    end else if (ctl.absb) begin
      u_y   = {{(WW-DW){b_r[DW-1]}}, b_r};
      u_sub = b_r[DW-1];
    end else if (ctl.mul) begin
      u_x   = {{(WW-DW){1'b0}}, hi_r};
      u_y   = lo_r[0] ? {{(WW-DW){1'b0}}, ma_r} : '0;
    end else if (ctl.div) begin
      u_x   = {{(WW-DW-1){1'b0}}, hi_r, dvd_r[VW-1]};
      u_y   = {{(WW-DW){1'b0}}, mb_r};
      u_sub = 1'b1;
    end else if (ctl.neg) begin
      u_y   = ctl.is_mul ? {hi_r, lo_r} : {{(WW-DW){1'b0}}, lo_r};
      u_sub = 1'b1;
    end
  end

  // A non-negative trial difference means the divisor fits.
  assign q_bit = !u_sum[WW-1];
  assign prod  = neg_r ? u_sum : {hi_r, lo_r};

  always_comb begin
    case (op_r)
      fpa_pkg::OP_SHL: simple_res = acc_r << sh_r;
      fpa_pkg::OP_SAR: simple_res = DW'($signed(acc_r) >>> sh_r);
      default:         simple_res = u_sum[DW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r   <= in_op;
      b_r    <= in_operand;
      sh_r   <= in_shift_amount;
      flag_r <= div_zero;
      neg_r  <= acc_r[DW-1] ^ in_operand[DW-1];
      res_r  <= acc_r;
    end
    if (ctl.simple) begin
      res_r <= simple_res;
    end
    if (ctl.absa) begin
      ma_r <= u_sum[DW-1:0];
    end
    if (ctl.absb) begin
      mb_r  <= u_sum[DW-1:0];
      hi_r  <= '0;
      lo_r  <= ctl.is_mul ? u_sum[DW-1:0] : '0;
      dvd_r <= VW'(ma_r) << fpa_pkg::FRAC_BITS;
    end
    if (ctl.mul) begin
      hi_r <= u_sum[DW:1];
      lo_r <= {u_sum[0], lo_r[DW-1:1]};
    end
    if (ctl.div) begin
      hi_r  <= q_bit ? u_sum[DW-1:0] : u_x[DW-1:0];
      lo_r  <= {lo_r[DW-2:0], q_bit};
      dvd_r <= dvd_r << 1;
    end
    if (ctl.neg) begin
      res_r <= ctl.is_mul ? prod[fpa_pkg::FRAC_BITS +: DW]
                          : (neg_r ? u_sum[DW-1:0] : lo_r);
    end
    if (ctl.fin && out_free) begin
      out_value_r <= res_r;
      out_flag_r  <= flag_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.fin && out_free) begin
        acc_r       <= res_r;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = out_value_r;
  assign out_div_by_zero = out_flag_r;

endmodule

// ----- rtl/core/fpa_chk.sv -----
`timescale 1ns / 1ps
module fpa_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [fpa_pkg::DATA_W-1:0]  out_value,
  input logic                        out_div_by_zero
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_div_by_zero))
    else $error("result beat changed while stalled");

  // Input ready drops straight after an accepted beat, so every operation keeps the block busy.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input ready straight after an accepted beat");

  // A fresh result coincides with the sequencer going back to idle.
  a_ready_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("result presented while the sequencer is still busy");

  // Reset leaves the block empty and ready.
  a_reset_state: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && in_ready)
    else $error("block not empty and ready after reset");

endmodule

bind fixed_point_accumulator_alu_core fpa_chk u_fpa_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_value       (out_value),
  .out_div_by_zero (out_div_by_zero)
);

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  typedef struct packed {
    logic [fpa_pkg::DATA_W-1:0] value;
    logic                       flag;
  } acc_result_t;

  logic                              clk = 1'b0;
  logic                              rst_n;
  logic                              in_valid;
  logic                              in_ready;
  logic [fpa_pkg::OP_W-1:0]          in_op;
  logic signed [fpa_pkg::DATA_W-1:0] in_operand;
  logic [fpa_pkg::SHIFT_W-1:0]       in_shift_amount;
  logic                              out_valid;
  logic                              out_ready;
  logic signed [fpa_pkg::DATA_W-1:0] out_value;
  logic                              out_div_by_zero;

  acc_result_t                acc_results_due[$];
  logic [fpa_pkg::DATA_W-1:0] model_acc = '0;
  int                         fail_count = 0;
  int                         results_checked = 0;
  int                         zero_div_seen = 0;
  int                         op_seen[8];
  bit                         src_idle_en = 1'b0;
  bit                         sink_stall_en = 1'b0;
  int                         sink_hold = 0;

  fixed_point_accumulator_alu_core u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_operand      (in_operand),
    .in_shift_amount (in_shift_amount),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_value       (out_value),
    .out_div_by_zero (out_div_by_zero)
  );

  always #6 clk = ~clk;

  // New accumulator and divide-by-zero flag for one operation.
  function automatic acc_result_t fixed_point_op(logic [fpa_pkg::DATA_W-1:0]  acc,
                                                 logic [fpa_pkg::OP_W-1:0]    op,
                                                 logic [fpa_pkg::DATA_W-1:0]  b,
                                                 logic [fpa_pkg::SHIFT_W-1:0] sh);
    acc_result_t        r;
    logic signed [63:0] prod;
    logic [63:0]        mag_a;
    logic [63:0]        mag_b;
    logic [63:0]        quot;
    r.value = acc;
    r.flag  = 1'b0;
    case (op)
      fpa_pkg::OP_SHL: r.value = acc << sh;
      fpa_pkg::OP_SAR: r.value = $signed(acc) >>> sh;
      fpa_pkg::OP_ADD: r.value = acc + b;
      fpa_pkg::OP_SUB: r.value = acc - b;
      fpa_pkg::OP_MUL: begin
        prod    = $signed({{32{acc[31]}}, acc}) * $signed({{32{b[31]}}, b});
        prod    = prod >>> fpa_pkg::FRAC_BITS;
        r.value = prod[31:0];
      end
      fpa_pkg::OP_DIV: begin
        if (b == '0) begin
          r.flag = 1'b1;
        end else begin
          mag_a = {{32{acc[31]}}, acc};
          if (acc[31]) mag_a = -mag_a;
          mag_a = mag_a << fpa_pkg::FRAC_BITS;
          mag_b = {{32{b[31]}}, b};
          if (b[31]) mag_b = -mag_b;
          quot = mag_a / mag_b;
          if (acc[31] ^ b[31]) quot = -quot;
          r.value = quot[31:0];
        end
      end
      fpa_pkg::OP_INC: r.value = acc + 1;
      default: r.value = acc - 1;
    endcase
    return r;
  endfunction

  // Results are checked before the new beat is predicted, since a result can leave at the
  // same edge as the next beat enters.
  always @(posedge clk) begin
    acc_result_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (acc_results_due.size() == 0) begin
          $display("%0t: result with none pending: value %h flag %b", $time, out_value,
                   out_div_by_zero);
          fail_count++;
        end else begin
          want = acc_results_due.pop_front();
          if (out_value !== want.value) begin
            $display("%0t: value expected %h, got %h", $time, want.value, out_value);
            fail_count++;
          end
          if (out_div_by_zero !== want.flag) begin
            $display("%0t: div_by_zero expected %b, got %b", $time, want.flag, out_div_by_zero);
            fail_count++;
          end
          results_checked++;
        end
      end
      if (in_valid && in_ready) begin
        want      = fixed_point_op(model_acc, in_op, in_operand, in_shift_amount);
        model_acc = want.value;
        acc_results_due.push_back(want);
        op_seen[in_op]++;
        if (want.flag) zero_div_seen++;
      end
    end
  end

  // Receiver: random stall bursts, or one long hold-off when asked for.
  initial begin : sink
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_hold > 0) begin
        out_ready <= 1'b0;
        n = sink_hold;
        sink_hold = 0;
        repeat (n - 1) @(negedge clk);
      end else if (sink_stall_en && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 11) - 1) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Valid stays high from one beat to the next unless an idle burst falls between them.
  task automatic send_op(logic [fpa_pkg::OP_W-1:0] op, logic [fpa_pkg::DATA_W-1:0] operand,
                         logic [fpa_pkg::SHIFT_W-1:0] sh);
    @(negedge clk);
    if (src_idle_en && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_operand      <= operand;
    in_shift_amount <= sh;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic test_corner_ops();
    send_op(fpa_pkg::OP_INC, 32'h0, 5'h0);
    send_op(fpa_pkg::OP_DEC, 32'h0, 5'h0);
    send_op(fpa_pkg::OP_DEC, 32'hffff_ffff, 5'h1f);
    send_op(fpa_pkg::OP_SAR, 32'h0, 5'd31);
    send_op(fpa_pkg::OP_ADD, 32'h7fff_ffff, 5'h0);
    send_op(fpa_pkg::OP_INC, 32'h0, 5'h0);
    send_op(fpa_pkg::OP_SAR, 32'h0, 5'd0);
    send_op(fpa_pkg::OP_SHL, 32'h0, 5'd0);
    send_op(fpa_pkg::OP_SAR, 32'h0, 5'd31);
    send_op(fpa_pkg::OP_SHL, 32'h0, 5'd31);
    send_op(fpa_pkg::OP_MUL, 32'h8000_0000, 5'h0);
    send_op(fpa_pkg::OP_SUB, 32'h8000_0000, 5'h0);
    send_op(fpa_pkg::OP_MUL, 32'h8000_0000, 5'h0);
    send_op(fpa_pkg::OP_ADD, 32'h0000_1234, 5'h0);
    send_op(fpa_pkg::OP_MUL, 32'h7fff_ffff, 5'h0);
    send_op(fpa_pkg::OP_MUL, 32'h0000_0100, 5'h0);
    send_op(fpa_pkg::OP_DIV, 32'h0, 5'h0);
    send_op(fpa_pkg::OP_DIV, 32'hffff_ffff, 5'h0);
    send_op(fpa_pkg::OP_DIV, 32'h0000_0100, 5'h0);
    send_op(fpa_pkg::OP_DIV, 32'h8000_0000, 5'h0);
    send_op(fpa_pkg::OP_SUB, 32'h7fff_ffff, 5'h0);
    send_op(fpa_pkg::OP_DIV, 32'h7fff_ffff, 5'h0);
    send_op(fpa_pkg::OP_DIV, 32'hffff_ff00, 5'h0);
    send_op(fpa_pkg::OP_SHL, 32'h5a5a_a5a5, 5'd16);
    send_op(fpa_pkg::OP_SAR, 32'h0, 5'd16);
  endtask

  task automatic send_random_op();
    logic [fpa_pkg::OP_W-1:0]   op;
    logic [fpa_pkg::DATA_W-1:0] operand;
    int                         pick;
    pick = $urandom_range(0, 99);
    if (pick < 10)      op = fpa_pkg::OP_SHL;
    else if (pick < 20) op = fpa_pkg::OP_SAR;
    else if (pick < 35) op = fpa_pkg::OP_ADD;
    else if (pick < 50) op = fpa_pkg::OP_SUB;
    else if (pick < 65) op = fpa_pkg::OP_MUL;
    else if (pick < 80) op = fpa_pkg::OP_DIV;
    else if (pick < 90) op = fpa_pkg::OP_INC;
    else                op = fpa_pkg::OP_DEC;
    case ($urandom_range(0, 9))
      0: operand = '0;
      1: begin
        case ($urandom_range(0, 3))
          0: operand = 32'h8000_0000;
          1: operand = 32'h7fff_ffff;
          2: operand = 32'hffff_ffff;
          default: operand = 32'h0000_0001;
        endcase
      end
      2, 3, 4: operand = $urandom_range(0, 4095) - 2048;
      default: operand = $urandom();
    endcase
    send_op(op, operand, fpa_pkg::SHIFT_W'($urandom_range(0, 31)));
  endtask

  task automatic test_random_mix(int count);
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;
    repeat (count) send_random_op();
  endtask

  // The receiver holds off long enough for the core to fill and stall its input.
  task automatic test_backpressure_fill();
    sink_hold = 400;
    repeat (12) send_random_op();
  endtask

  task automatic test_streaming(int count);
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    repeat (count) send_random_op();
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = fpa_pkg::OP_SHL;
    in_operand      = '0;
    in_shift_amount = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_ops();
    test_random_mix(700);
    test_backpressure_fill();
    test_random_mix(60);
    test_streaming(100);

    @(negedge clk);
    in_valid <= 1'b0;
    while (acc_results_due.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Checked %0d results: shl %0d, sar %0d, add %0d, sub %0d, mul %0d, div %0d,",
             results_checked, op_seen[fpa_pkg::OP_SHL], op_seen[fpa_pkg::OP_SAR],
             op_seen[fpa_pkg::OP_ADD], op_seen[fpa_pkg::OP_SUB], op_seen[fpa_pkg::OP_MUL],
             op_seen[fpa_pkg::OP_DIV]);
    $display("inc %0d, dec %0d; %0d divides by zero, one long output stall.",
             op_seen[fpa_pkg::OP_INC], op_seen[fpa_pkg::OP_DEC], zero_div_seen);
    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #(12 * 500000);
    $display("Timeout with %0d results still pending.", acc_results_due.size());
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/fpa_pkg.sv
rtl/core/fpa_addsub.sv
rtl/core/fpa_seq.sv
rtl/core/fixed_point_accumulator_alu_core.sv
rtl/core/fpa_chk.sv
tb/testbench.sv
